>>> rtl/rlds_pkg.sv
// Shared constants, codes and types for the run-length deduplicating stack.
package rlds_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int COPY_WIDTH = 16;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ENTRIES_W  = 7;

    localparam logic [COPY_WIDTH-1:0] COPY_MAX = {COPY_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        REQ_PUSH      = 2'd0,
        REQ_PUSH_COPY = 2'd1,
        REQ_POP       = 2'd2,
        REQ_PEEK      = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_FULL       = 2'd2,
        ST_COUNT_FULL = 2'd3
    } status_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic [COPY_WIDTH-1:0] copies;
    } entry_t;

endpackage

>>> rtl/run_length_dedup_stack.sv
// Run-length deduplicating stack: top entry in registers, lower entries in a memory.
// The result of a request is registered when its request transaction is accepted.
// Throughput: one request per cycle while no result is stalled; the top entry and the
// one below are registers, the latter refilled each cycle by a registered memory read.
// Reset (aresetn low, synchronous): stack empty, dedup_enable set, no result pending.
// Memory contents are not cleared; only entries below the fill count are ever used.
module run_length_dedup_stack (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_req_type,
    input  logic [rlds_pkg::DATA_WIDTH-1:0]    s_data_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rlds_pkg::DATA_WIDTH-1:0]    m_data_out,
    output logic [1:0]                         m_status,
    output logic                               m_now_empty,
    output logic [rlds_pkg::COPY_WIDTH-1:0]    m_top_copies,
    output logic [rlds_pkg::ENTRIES_W-1:0]     m_entries_used
);

    // State registers
    logic                              dedup_reg;
    logic [rlds_pkg::CNT_W-1:0]        count_reg, count_next;
    rlds_pkg::entry_t                  top_reg, top_next;
    rlds_pkg::entry_t                  mem_rd_reg;
    rlds_pkg::entry_t                  byp_data_reg;
    logic                              byp_reg;
    rlds_pkg::entry_t                  mem [rlds_pkg::DEPTH];

    // Result register
    logic                              out_valid_reg;
    logic [rlds_pkg::DATA_WIDTH-1:0]   out_data_reg;
    logic [1:0]                        out_status_reg;
    logic                              out_empty_reg;
    logic [rlds_pkg::COPY_WIDTH-1:0]   out_copies_reg;
    logic [rlds_pkg::ENTRIES_W-1:0]    out_entries_reg;

    logic                              accept;
    logic                              push_new;
    rlds_pkg::entry_t                  second;
    rlds_pkg::req_t                    req;
    rlds_pkg::status_t                 status;
    logic [rlds_pkg::DATA_WIDTH-1:0]   rd_data;
    logic [rlds_pkg::CNT_W-1:0]        count_m1;
    logic [rlds_pkg::CNT_W-1:0]        rd_cnt;
    logic [rlds_pkg::ADDR_W-1:0]       wr_addr;
    logic [rlds_pkg::ADDR_W-1:0]       rd_addr;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign req     = rlds_pkg::req_t'(s_req_type);

    // Entry below the top: bypass the value just pushed down
    assign second   = byp_reg ? byp_data_reg : mem_rd_reg;
    assign count_m1 = count_reg - rlds_pkg::CNT_W'(1);
    assign wr_addr  = count_m1[rlds_pkg::ADDR_W-1:0];
    assign rd_cnt   = count_next - rlds_pkg::CNT_W'(2);
    assign rd_addr  = rd_cnt[rlds_pkg::ADDR_W-1:0];

    // Serve the request against the top entry
    always_comb begin
        count_next = count_reg;
        top_next   = top_reg;
        status     = rlds_pkg::ST_OK;
        rd_data    = '0;
        push_new   = 1'b0;
        if (accept) begin
            unique case (req)
                rlds_pkg::REQ_PUSH: begin
                    if (count_reg != '0 && dedup_reg && top_reg.value == s_data_in) begin
                        if (top_reg.copies == rlds_pkg::COPY_MAX) begin
                            status = rlds_pkg::ST_COUNT_FULL;
                        end else begin
                            top_next.copies = top_reg.copies + rlds_pkg::COPY_WIDTH'(1);
                        end
                    end else if (count_reg == rlds_pkg::CNT_W'(rlds_pkg::DEPTH)) begin
                        status = rlds_pkg::ST_FULL;
                    end else begin
                        push_new        = 1'b1;
                        top_next.value  = s_data_in;
                        top_next.copies = rlds_pkg::COPY_WIDTH'(1);
                        count_next      = count_reg + rlds_pkg::CNT_W'(1);
                    end
                end
                rlds_pkg::REQ_PUSH_COPY: begin
                    if (count_reg == '0) begin
                        status = rlds_pkg::ST_EMPTY;
                    end else if (top_reg.copies == rlds_pkg::COPY_MAX) begin
                        status = rlds_pkg::ST_COUNT_FULL;
                    end else begin
                        top_next.copies = top_reg.copies + rlds_pkg::COPY_WIDTH'(1);
                    end
                end
                rlds_pkg::REQ_POP: begin
                    if (count_reg == '0) begin
                        status = rlds_pkg::ST_EMPTY;
                    end else begin
                        rd_data = top_reg.value;
                        if (top_reg.copies <= rlds_pkg::COPY_WIDTH'(1)) begin
                            top_next   = second;
                            count_next = count_m1;
                        end else begin
                            top_next.copies = top_reg.copies - rlds_pkg::COPY_WIDTH'(1);
                        end
                    end
                end
                rlds_pkg::REQ_PEEK: begin
                    if (count_reg == '0) begin
                        status = rlds_pkg::ST_EMPTY;
                    end else begin
                        rd_data = top_reg.value;
                    end
                end
                default: begin
                    status = rlds_pkg::ST_OK;
                end
            endcase
        end
    end

    // Spill the old top on a new entry; prefetch the entry below the next top
    always_ff @(posedge aclk) begin
        if (push_new && count_reg != '0) begin
            mem[wr_addr] <= top_reg;
        end
        mem_rd_reg   <= mem[rd_addr];
        byp_data_reg <= top_reg;
        top_reg      <= top_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dedup_reg <= 1'b1;
            count_reg <= '0;
            byp_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                dedup_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            byp_reg   <= push_new && count_reg != '0;
        end
    end

    // Hold the result until the transaction completes downstream
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg    <= rd_data;
            out_status_reg  <= status;
            out_empty_reg   <= (count_next == '0);
            out_copies_reg  <= (count_next == '0) ? '0 : top_next.copies;
            out_entries_reg <= rlds_pkg::ENTRIES_W'(count_next);
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_data_out     = out_data_reg;
    assign m_status       = out_status_reg;
    assign m_now_empty    = out_empty_reg;
    assign m_top_copies   = out_copies_reg;
    assign m_entries_used = out_entries_reg;

endmodule

>>> rtl/rlds_checker.sv
// Port-level checker for the run-length deduplicating stack, with its bind.
module rlds_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [rlds_pkg::DATA_WIDTH-1:0]    m_data_out,
    input logic [1:0]                         m_status,
    input logic                               m_now_empty,
    input logic [rlds_pkg::COPY_WIDTH-1:0]    m_top_copies,
    input logic [rlds_pkg::ENTRIES_W-1:0]     m_entries_used
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out) && $stable(m_status))
        else $error("result changed while stalled");

    // Empty flag agrees with the entry count
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_now_empty == (m_entries_used == '0)))
        else $error("now_empty disagrees with entries_used");

    // An empty stack shows no copies, a non-empty one at least one
    a_empty_copies: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_now_empty == (m_top_copies == '0)))
        else $error("top_copies disagrees with now_empty");

    // Never report more entries than the depth
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_entries_used <= rlds_pkg::ENTRIES_W'(rlds_pkg::DEPTH)))
        else $error("entries_used beyond depth");

    // A request refused as full or empty leaves data_out at zero
    a_err_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == rlds_pkg::ST_FULL || m_status == rlds_pkg::ST_EMPTY)
        |-> (m_data_out == '0))
        else $error("data_out not zero on error");

endmodule

bind run_length_dedup_stack rlds_checker u_rlds_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_data_out     (m_data_out),
    .m_status       (m_status),
    .m_now_empty    (m_now_empty),
    .m_top_copies   (m_top_copies),
    .m_entries_used (m_entries_used)
);
